// File: design/lpr_pkg.sv
package lpr_pkg;

  localparam int SLOTS     = 16;
  localparam int PAGE_BITS = 16;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RANK_W    = SLOT_W;
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int CFG_W     = 5;
  localparam int FAULT_W   = 32;

  typedef struct packed {
    logic [15:0] page_number;
    logic        end_of_string;
  } in_word_t;

  typedef struct packed {
    logic         hit;
    logic [3:0]   slot_index;
    logic         evicted_valid;
    logic [15:0]  evicted_page;
    logic [31:0]  fault_total;
    logic         is_last;
  } out_word_t;

  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic [RANK_W-1:0]    rank;
  } entry_t;

  typedef struct packed {
    logic                 valid;
    logic                 age_all;
    logic [SLOT_W-1:0]    slot;
    logic [RANK_W-1:0]    rank;
    logic [PAGE_BITS-1:0] page;
  } pend_t;

  typedef struct packed {
    logic                 found;
    logic [SLOT_W-1:0]    hit_slot;
    logic [RANK_W-1:0]    hit_rank;
    logic [SLOT_W-1:0]    old_slot;
    logic [RANK_W-1:0]    old_rank;
    logic [PAGE_BITS-1:0] old_page;
  } scan_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

// File: design/lpr_ram.sv
module lpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/lpr_merge.sv
module lpr_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_vld,
  input  logic [lpr_pkg::SLOT_W-1:0]    rd_idx,
  input  lpr_pkg::entry_t               rd_entry,
  input  logic [lpr_pkg::PAGE_BITS-1:0] page,
  input  logic                          start,
  input  logic                          pend_load,
  input  lpr_pkg::pend_t                pend_in,
  input  logic                          pend_drop,
  output lpr_pkg::entry_t               wr_entry,
  output lpr_pkg::scan_t                scan
);

  lpr_pkg::pend_t  pend_r, pend_nxt;
  lpr_pkg::scan_t  scan_r, scan_nxt;
  lpr_pkg::entry_t adj;

  // apply the previous word's recency update to the entry as it streams by
  always_comb begin
    adj = rd_entry;
    if (pend_r.valid) begin
      if (rd_idx == pend_r.slot) begin
        adj.page = pend_r.page;
        adj.rank = '0;
      end else if (pend_r.age_all || (rd_entry.rank < pend_r.rank)) begin
        adj.rank = rd_entry.rank + lpr_pkg::RANK_W'(1);
      end
    end
  end

  always_comb begin
    scan_nxt = scan_r;
    if (start) begin
      scan_nxt = '0;
    end else if (rd_vld) begin
      if (!scan_r.found && (adj.page == page)) begin
        scan_nxt.found    = 1'b1;
        scan_nxt.hit_slot = rd_idx;
        scan_nxt.hit_rank = adj.rank;
      end
      if ((rd_idx == '0) || (adj.rank > scan_r.old_rank)) begin
        scan_nxt.old_slot = rd_idx;
        scan_nxt.old_rank = adj.rank;
        scan_nxt.old_page = adj.page;
      end
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (pend_drop) begin
      pend_nxt.valid = 1'b0;
    end else if (pend_load) begin
      pend_nxt = pend_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      scan_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      scan_r <= scan_nxt;
    end
  end

  assign wr_entry = adj;
  assign scan     = scan_r;

endmodule

// File: design/lru_page_replacement_core.sv
// LRU page-frame store: each input word references one page; the result word
// reports hit or fault, the frame now holding the page, any evicted page and
// the saturating fault total. The store accepts no new word until the last one's
// result is in the output register. Each item takes one pass over the occupied
// frames of the memory, one entry per cycle through its single read port; each
// entry is read, brought up to date and written back in that pass. A finished
// result waits in the output register without blocking the
// next accept. A word marked last clears the store and the fault total after
// its result. cfg_wdata sets the frame limit (0 acts as 1, above 16 as 16).
module lru_page_replacement_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [lpr_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  lpr_pkg::in_word_t          in_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output lpr_pkg::out_word_t         out_word
);

  lpr_pkg::state_t state_r, state_nxt;

  logic [lpr_pkg::CFG_W-1:0]     cfg_r, cfg_nxt;
  logic [lpr_pkg::CNT_W-1:0]     occ_r, occ_nxt;
  logic [lpr_pkg::FAULT_W-1:0]   fault_r, fault_nxt;
  logic [lpr_pkg::CNT_W-1:0]     idx_r, idx_nxt;
  logic                          rd_vld_r;
  logic [lpr_pkg::SLOT_W-1:0]    rd_idx_r;
  logic [lpr_pkg::PAGE_BITS-1:0] page_r, page_nxt;
  logic                          last_r, last_nxt;
  logic                          out_valid_r, out_valid_nxt;
  lpr_pkg::out_word_t            out_word_r, out_word_nxt;

  logic                          in_accept;
  logic                          issue;
  logic                          deposit;
  logic [lpr_pkg::CNT_W-1:0]     limit;
  lpr_pkg::entry_t               rd_entry;
  lpr_pkg::entry_t               wr_entry;
  lpr_pkg::scan_t                scan;
  lpr_pkg::pend_t                pend_in;
  logic [lpr_pkg::SLOT_W-1:0]    slot;
  logic                          ev_valid;
  logic [lpr_pkg::PAGE_BITS-1:0] ev_page;

  lpr_ram #(
    .WIDTH ($bits(lpr_pkg::entry_t)),
    .DEPTH (lpr_pkg::SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (rd_vld_r),
    .wr_addr (rd_idx_r),
    .wr_data (wr_entry),
    .rd_addr (idx_r[lpr_pkg::SLOT_W-1:0]),
    .rd_data (rd_entry)
  );

  lpr_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_vld    (rd_vld_r),
    .rd_idx    (rd_idx_r),
    .rd_entry  (rd_entry),
    .page      (page_r),
    .start     (in_accept),
    .pend_load (deposit),
    .pend_in   (pend_in),
    .pend_drop (deposit && last_r),
    .wr_entry  (wr_entry),
    .scan      (scan)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = lpr_pkg::ST_SCAN;
        end
      end
      lpr_pkg::ST_SCAN: begin
        if (!issue && !rd_vld_r) begin
          state_nxt = lpr_pkg::ST_FINISH;
        end
      end
      lpr_pkg::ST_FINISH: begin
        if (deposit) begin
          state_nxt = lpr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lpr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall  = (state_r != lpr_pkg::ST_IDLE);
    in_accept = in_valid && (state_r == lpr_pkg::ST_IDLE);
    issue     = (state_r == lpr_pkg::ST_SCAN) && (idx_r < occ_r);
    deposit   = (state_r == lpr_pkg::ST_FINISH) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    if (cfg_r == '0) begin
      limit = lpr_pkg::CNT_W'(1);
    end else if (cfg_r > lpr_pkg::CFG_W'(lpr_pkg::SLOTS)) begin
      limit = lpr_pkg::CNT_W'(lpr_pkg::SLOTS);
    end else begin
      limit = lpr_pkg::CNT_W'(cfg_r);
    end
  end

  always_comb begin
    slot     = scan.old_slot;
    ev_valid = 1'b0;
    ev_page  = '0;
    occ_nxt  = occ_r;
    pend_in  = '{valid: 1'b1, age_all: 1'b0, slot: scan.old_slot,
                 rank: scan.old_rank, page: page_r};
    if (scan.found) begin
      slot         = scan.hit_slot;
      pend_in.slot = scan.hit_slot;
      pend_in.rank = scan.hit_rank;
    end else if (occ_r < limit) begin
      slot            = occ_r[lpr_pkg::SLOT_W-1:0];
      pend_in.slot    = occ_r[lpr_pkg::SLOT_W-1:0];
      pend_in.age_all = 1'b1;
      pend_in.rank    = '0;
      if (deposit) begin
        occ_nxt = occ_r + lpr_pkg::CNT_W'(1);
      end
    end else begin
      ev_valid = 1'b1;
      ev_page  = scan.old_page;
    end

    fault_nxt = fault_r;
    if (deposit && !scan.found && (fault_r != '1)) begin
      fault_nxt = fault_r + lpr_pkg::FAULT_W'(1);
    end

    out_word_nxt = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (deposit) begin
      out_valid_nxt              = 1'b1;
      out_word_nxt.hit           = scan.found;
      out_word_nxt.slot_index    = 4'(slot);
      out_word_nxt.evicted_valid = ev_valid;
      out_word_nxt.evicted_page  = 16'(ev_page);
      out_word_nxt.fault_total   = 32'(fault_nxt);
      out_word_nxt.is_last       = last_r;
      if (last_r) begin
        occ_nxt   = '0;
        fault_nxt = '0;
      end
    end
  end

  always_comb begin
    cfg_nxt  = cfg_we ? cfg_wdata : cfg_r;
    idx_nxt  = idx_r;
    page_nxt = page_r;
    last_nxt = last_r;
    if (in_accept) begin
      idx_nxt  = '0;
      page_nxt = lpr_pkg::PAGE_BITS'(in_word.page_number);
      last_nxt = in_word.end_of_string;
    end else if (issue) begin
      idx_nxt = idx_r + lpr_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpr_pkg::ST_IDLE;
      cfg_r       <= lpr_pkg::CFG_W'(lpr_pkg::SLOTS);
      occ_r       <= '0;
      fault_r     <= '0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_r       <= cfg_nxt;
      occ_r       <= occ_nxt;
      fault_r     <= fault_nxt;
      idx_r       <= idx_nxt;
      rd_vld_r    <= issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= idx_r[lpr_pkg::SLOT_W-1:0];
    page_r     <= page_nxt;
    last_r     <= last_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= lpr_pkg::CNT_W'(lpr_pkg::SLOTS))
    else $error("occupancy beyond frame count");

  a_wb_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == lpr_pkg::ST_SCAN))
    else $error("memory write-back outside scan");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == lpr_pkg::ST_FINISH))
    else $error("result loaded outside finish");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.hit) |-> !out_word_r.evicted_valid)
    else $error("hit reports an eviction");

endmodule
